FILE: rtl/roman_numeral_encoder_core_assert.svh
// Assertion macros used by the Roman numeral encoder core.
`ifndef ROMAN_NUMERAL_ENCODER_CORE_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define REN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed in roman numeral encoder.");

// Next-cycle implication checked at every clock edge outside reset.
`define REN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed in roman numeral encoder.");

`endif

FILE: rtl/ren_pkg.sv
// Shared types, constants and tables of the Roman numeral encoder.
package ren_pkg;

  localparam int VALUE_W    = 12;
  localparam int CHAR_W     = 7;
  localparam int NUM_PLACES = 4;
  localparam int PLACE_W    = 2;
  localparam int DIGIT_W    = 4;
  localparam int UADDR_W    = 4;
  localparam int MULT_W     = 14;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  localparam logic [PLACE_W-1:0] PL_ONES      = 2'd0;
  localparam logic [PLACE_W-1:0] PL_TENS      = 2'd1;
  localparam logic [PLACE_W-1:0] PL_HUNDREDS  = 2'd2;
  localparam logic [PLACE_W-1:0] PL_THOUSANDS = 2'd3;

  localparam logic [CHAR_W-1:0] CH_I   = 7'h49;
  localparam logic [CHAR_W-1:0] CH_V   = 7'h56;
  localparam logic [CHAR_W-1:0] CH_X   = 7'h58;
  localparam logic [CHAR_W-1:0] CH_L   = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_C   = 7'h43;
  localparam logic [CHAR_W-1:0] CH_D   = 7'h44;
  localparam logic [CHAR_W-1:0] CH_M   = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;

  typedef logic [NUM_PLACES-1:0][DIGIT_W-1:0] digits_t;

  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_t;

  typedef struct packed {
    sym_t               sym;
    logic               digit_end;
    logic [UADDR_W-1:0] next;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic done;
  } split_stat_t;

  // Microprogram: the program for digit d starts at address d - 1.
  function automatic uword_t ucode(logic [UADDR_W-1:0] addr);
    uword_t w;
    w = '{sym: SYM_ONE, digit_end: 1'b1, next: 4'd0};
    unique case (addr)
      4'd0:    w = '{sym: SYM_ONE,  digit_end: 1'b1, next: 4'd0};
      4'd1:    w = '{sym: SYM_ONE,  digit_end: 1'b0, next: 4'd0};
      4'd2:    w = '{sym: SYM_ONE,  digit_end: 1'b0, next: 4'd1};
      4'd3:    w = '{sym: SYM_ONE,  digit_end: 1'b0, next: 4'd4};
      4'd4:    w = '{sym: SYM_FIVE, digit_end: 1'b1, next: 4'd0};
      4'd5:    w = '{sym: SYM_FIVE, digit_end: 1'b0, next: 4'd0};
      4'd6:    w = '{sym: SYM_FIVE, digit_end: 1'b0, next: 4'd1};
      4'd7:    w = '{sym: SYM_FIVE, digit_end: 1'b0, next: 4'd2};
      4'd8:    w = '{sym: SYM_ONE,  digit_end: 1'b0, next: 4'd9};
      4'd9:    w = '{sym: SYM_TEN,  digit_end: 1'b1, next: 4'd0};
      default: w = '{sym: SYM_ONE,  digit_end: 1'b1, next: 4'd0};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] letter(logic [PLACE_W-1:0] place, sym_t sym);
    logic [CHAR_W-1:0] ch;
    ch = CH_NUL;
    unique case (place)
      PL_ONES:      ch = (sym == SYM_ONE) ? CH_I : (sym == SYM_FIVE) ? CH_V : CH_X;
      PL_TENS:      ch = (sym == SYM_ONE) ? CH_X : (sym == SYM_FIVE) ? CH_L : CH_C;
      PL_HUNDREDS:  ch = (sym == SYM_ONE) ? CH_C : (sym == SYM_FIVE) ? CH_D : CH_M;
      PL_THOUSANDS: ch = (sym == SYM_ONE) ? CH_M : CH_NUL;
      default:      ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Returns k times the weight of the given decimal place, wide enough for 9000.
  function automatic logic [MULT_W-1:0] place_mult(logic [PLACE_W-1:0] place,
                                                   logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] m;
    m = '0;
    unique case (place)
      PL_THOUSANDS: m = MULT_W'(k * 1000);
      PL_HUNDREDS:  m = MULT_W'(k * 100);
      PL_TENS:      m = MULT_W'(k * 10);
      PL_ONES:      m = MULT_W'(k);
      default:      m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/ren_digit_split.sv
// Splits a value below 4000 into four decimal digits, thousands first; the ones digit is written with the tens.
module ren_digit_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ren_pkg::VALUE_W-1:0] value,
  output ren_pkg::digits_t            digits,
  output ren_pkg::split_stat_t        stat
);

  logic                        busy_r;
  logic                        done_r;
  logic [ren_pkg::PLACE_W-1:0] place_r;
  logic [ren_pkg::VALUE_W-1:0] rest_r;
  logic [ren_pkg::VALUE_W-1:0] rest_nxt;
  logic [ren_pkg::DIGIT_W-1:0] dig;
  ren_pkg::digits_t            digits_r;

  always_comb begin
    dig = '0;
    for (int k = 1; k < 10; k++) begin
      if (ren_pkg::MULT_W'(rest_r) >=
          ren_pkg::place_mult(place_r, ren_pkg::DIGIT_W'(k))) begin
        dig = ren_pkg::DIGIT_W'(k);
      end
    end
    rest_nxt = rest_r - ren_pkg::VALUE_W'(ren_pkg::place_mult(place_r, dig));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      place_r <= ren_pkg::PL_THOUSANDS;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        place_r <= ren_pkg::PL_THOUSANDS;
      end else if (busy_r) begin
        place_r <= place_r - 2'd1;
        if (place_r == ren_pkg::PL_TENS) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest_r <= value;
    end else if (busy_r) begin
      rest_r            <= rest_nxt;
      digits_r[place_r] <= dig;
      if (place_r == ren_pkg::PL_TENS) begin
        digits_r[ren_pkg::PL_ONES] <= rest_nxt[ren_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign digits    = digits_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/roman_numeral_encoder_core.sv
// Top level of the Roman numeral encoder: control, microcode sequencer and output register.
//
// The input channel (in_valid, in_ready, in_value) takes one 12-bit integer per transfer.
// The output channel (out_valid, out_ready, out_character, out_last, out_error) gives the
// Roman numeral as one ASCII letter per transfer, most significant first, with out_last
// set on the final letter. A value of zero or above 3999 gives a single transfer with
// out_error and out_last set and out_character zero.
// One item is handled at a time. A valid value is accepted and split into decimal digits
// by the digit splitter (thousands, hundreds and tens in turn, the ones digit with the
// tens), then the microcode sequencer gives one letter per cycle unless out_ready stalls
// the output. An out-of-range value goes from acceptance straight to the error transfer.
// The sequencer advances only when the output register is empty or being emptied, so a
// stall on out_ready holds the current letter and pauses the program without loss. A new
// input is taken as soon as the last letter of the previous item sits in the output register.
// Reset (rst_n low at a clock edge) returns the sequencer to idle and empties the output.
module roman_numeral_encoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ren_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ren_pkg::CHAR_W-1:0]  out_character,
  output logic                        out_last,
  output logic                        out_error
);

  `include "roman_numeral_encoder_core_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SPLIT = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [ren_pkg::PLACE_W-1:0] cur_r;
  logic [ren_pkg::PLACE_W-1:0] cur_nxt;
  logic [ren_pkg::UADDR_W-1:0] upc_r;
  logic [ren_pkg::UADDR_W-1:0] upc_nxt;

  logic                        out_valid_r;
  logic [ren_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_last_r;
  logic                        out_error_r;
  logic                        load;
  logic [ren_pkg::CHAR_W-1:0]  load_char;
  logic                        load_last;
  logic                        load_error;

  logic                        accept;
  logic                        bad_value;
  logic                        can_load;
  ren_pkg::digits_t            digits;
  ren_pkg::split_stat_t        split_stat;
  ren_pkg::uword_t             uword;
  logic [ren_pkg::NUM_PLACES-1:0] nz;
  logic [ren_pkg::NUM_PLACES-1:0] below;
  logic [ren_pkg::PLACE_W-1:0] top_place;
  logic [ren_pkg::PLACE_W-1:0] below_place;

  assign accept    = in_valid && in_ready;
  assign bad_value = (in_value == '0) || (in_value > ren_pkg::MAX_VALUE);
  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign uword     = ren_pkg::ucode(upc_r);

  ren_digit_split u_split (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && !bad_value),
    .value  (in_value),
    .digits (digits),
    .stat   (split_stat)
  );

  always_comb begin
    top_place   = ren_pkg::PL_ONES;
    below_place = ren_pkg::PL_ONES;
    for (int p = 0; p < ren_pkg::NUM_PLACES; p++) begin
      nz[p]    = (digits[p] != '0);
      below[p] = nz[p] && (ren_pkg::PLACE_W'(p) < cur_r);
    end
    for (int p = 0; p < ren_pkg::NUM_PLACES; p++) begin
      if (nz[p]) begin
        top_place = ren_pkg::PLACE_W'(p);
      end
      if (below[p]) begin
        below_place = ren_pkg::PLACE_W'(p);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    upc_nxt    = upc_r;
    load       = 1'b0;
    load_char  = ren_pkg::CH_NUL;
    load_last  = 1'b0;
    load_error = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = bad_value ? ST_ERR : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (split_stat.done) begin
          state_nxt = ST_EMIT;
          cur_nxt   = top_place;
          upc_nxt   = digits[top_place] - 4'd1;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          load      = 1'b1;
          load_char = ren_pkg::letter(cur_r, uword.sym);
          load_last = uword.digit_end && (below == '0);
          if (!uword.digit_end) begin
            upc_nxt = uword.next;
          end else if (below != '0) begin
            cur_nxt = below_place;
            upc_nxt = digits[below_place] - 4'd1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (can_load) begin
          load       = 1'b1;
          load_last  = 1'b1;
          load_error = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    upc_r <= upc_nxt;
    if (load) begin
      out_char_r  <= load_char;
      out_last_r  <= load_last;
      out_error_r <= load_error;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_error_r;

  `REN_ASSERT_SAME(a_err_shape, out_valid_r && out_error_r, out_last_r && (out_char_r == '0))
  `REN_ASSERT_NEXT(a_good_to_split, accept && !bad_value, state_r == ST_SPLIT && split_stat.busy)
  `REN_ASSERT_SAME(a_done_in_split, split_stat.done, state_r == ST_SPLIT)
  `REN_ASSERT_SAME(a_emit_nonzero, state_r == ST_EMIT, nz[cur_r] && !split_stat.busy)

endmodule
